>>> rtl/core/ptw_pkg.sv
// ----------------------------------------------------------------------------
// ptw_pkg
// Shared widths, result codes and item/state structs for the page walker.
// ----------------------------------------------------------------------------
`default_nettype none

package ptw_pkg;

    localparam int VA_W        = 48;
    localparam int PA_W        = 52;
    localparam int SIZE_W      = 32;
    localparam int ENTRY_W     = 64;
    localparam int LEN_W       = 13;
    localparam int IDX_W       = 9;
    localparam int PAGE_SHIFT  = 12;
    localparam int PRESENT_BIT = 0;
    localparam int LARGE_BIT   = 7;

    localparam int DEF_PHYS_FRAME_BITS = 36;

    localparam logic [LEN_W-1:0] PAGE_BYTES = LEN_W'(1 << PAGE_SHIFT);

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_FAULT = 2'd2
    } ptw_kind_t;

    typedef enum logic [0:0] {
        ACT_START = 1'b0,
        ACT_ENTRY = 1'b1
    } ptw_action_t;

    typedef struct packed {
        ptw_action_t         action;
        logic [VA_W-1:0]     linear_addr;
        logic [PA_W-1:0]     table_base;
        logic [SIZE_W-1:0]   request_size;
        logic [ENTRY_W-1:0]  entry_data;
    } ptw_item_t;

    typedef struct packed {
        ptw_kind_t           kind;
        logic [PA_W-1:0]     entry_address;
        logic [PA_W-1:0]     phys_addr;
        logic [LEN_W-1:0]    copy_length;
    } ptw_result_t;

    typedef struct packed {
        logic                busy;
        logic [1:0]          level;
        logic [VA_W-1:0]     linear_address;
        logic [LEN_W-1:0]    byte_count;
    } ptw_state_t;

endpackage

`default_nettype wire

>>> rtl/core/ptw_step.sv
// ----------------------------------------------------------------------------
// ptw_step
// One walk step: takes an item and the walk state, gives the result and the
// next walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_step
    import ptw_pkg::*;
#(
    parameter int PHYS_FRAME_BITS = DEF_PHYS_FRAME_BITS
)
(
    input  ptw_item_t   item,
    input  ptw_state_t  state,
    output logic        has_result,
    output ptw_result_t result,
    output ptw_state_t  state_next
);

    localparam logic [PA_W-1:0] TOP_MASK =
        PA_W'((64'd1 << PHYS_FRAME_BITS) - 64'd1);
    localparam logic [PA_W-1:0] FMASK_4K = TOP_MASK & ~PA_W'((64'd1 << PAGE_SHIFT) - 64'd1);
    localparam logic [PA_W-1:0] FMASK_2M = TOP_MASK & ~PA_W'((64'd1 << 21) - 64'd1);
    localparam logic [PA_W-1:0] FMASK_1G = TOP_MASK & ~PA_W'((64'd1 << 30) - 64'd1);

    function automatic logic [IDX_W-1:0] level_index(input logic [VA_W-1:0] va,
                                                     input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                2'd0:    idx = va[47:39];
                2'd1:    idx = va[38:30];
                2'd2:    idx = va[29:21];
                2'd3:    idx = va[20:12];
                default: idx = va[47:39];
            endcase
            return idx;
        end
    endfunction

    logic [1:0]        next_level;
    logic [PA_W-1:0]   top_addr;
    logic [PA_W-1:0]   next_addr;
    logic [PA_W-1:0]   entry_frame;
    logic [PA_W-1:0]   pa_1g;
    logic [PA_W-1:0]   pa_2m;
    logic [PA_W-1:0]   pa_4k;
    logic [PA_W-1:0]   pa_sel;
    logic [LEN_W-1:0]  size_clamped;
    logic [LEN_W-1:0]  page_left;
    logic [LEN_W-1:0]  done_len;
    logic              present;
    logic              large_page;

    assign next_level   = state.level + 2'd1;
    assign top_addr     = {item.table_base[PA_W-1:4], 4'b0000}
                        + {{(PA_W-IDX_W-3){1'b0}}, level_index(item.linear_addr, 2'd0), 3'b000};
    assign entry_frame  = item.entry_data[PA_W-1:0] & FMASK_4K;
    assign next_addr    = entry_frame
                        + {{(PA_W-IDX_W-3){1'b0}}, level_index(state.linear_address, next_level),
                           3'b000};
    assign pa_1g        = (item.entry_data[PA_W-1:0] & FMASK_1G)
                        | {{(PA_W-30){1'b0}}, state.linear_address[29:0]};
    assign pa_2m        = (item.entry_data[PA_W-1:0] & FMASK_2M)
                        | {{(PA_W-21){1'b0}}, state.linear_address[20:0]};
    assign pa_4k        = entry_frame
                        | {{(PA_W-PAGE_SHIFT){1'b0}}, state.linear_address[PAGE_SHIFT-1:0]};
    assign size_clamped = (item.request_size < SIZE_W'(PAGE_BYTES))
                        ? item.request_size[LEN_W-1:0] : PAGE_BYTES;
    assign present      = item.entry_data[PRESENT_BIT];
    assign large_page   = item.entry_data[LARGE_BIT];
    assign pa_sel       = (state.level == 2'd1) ? pa_1g
                        : (state.level == 2'd2) ? pa_2m : pa_4k;
    assign page_left    = PAGE_BYTES - {1'b0, pa_sel[PAGE_SHIFT-1:0]};
    assign done_len     = (state.byte_count < page_left) ? state.byte_count : page_left;

    always_comb
    begin
        has_result = 1'b0;
        result     = '{kind: KIND_FAULT, entry_address: '0, phys_addr: '0,
                       copy_length: '0};
        state_next = state;
        if (item.action == ACT_START) begin
            if (!state.busy) begin
                has_result                = 1'b1;
                state_next.linear_address = item.linear_addr;
                state_next.byte_count     = size_clamped;
                state_next.level          = 2'd0;
                if (item.table_base != '0) begin
                    if (top_addr != '0) begin
                        state_next.busy      = 1'b1;
                        result.kind          = KIND_READ;
                        result.entry_address = top_addr;
                    end
                end
            end
        end else if (state.busy) begin
            has_result      = 1'b1;
            state_next.busy = 1'b0;
            if (state.level != 2'd3 && !present) begin
                // absent entry: fault, walk ends
            end else if ((state.level == 2'd1 || state.level == 2'd2) && large_page) begin
                result.kind        = KIND_DONE;
                result.phys_addr   = pa_sel;
                result.copy_length = done_len;
            end else if (state.level == 2'd3) begin
                if (entry_frame != '0) begin
                    result.kind        = KIND_DONE;
                    result.phys_addr   = pa_sel;
                    result.copy_length = done_len;
                end
            end else begin
                state_next.level = next_level;
                if (next_addr != '0) begin
                    state_next.busy      = 1'b1;
                    result.kind          = KIND_READ;
                    result.entry_address = next_addr;
                end
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ptw_obuf.sv
// ----------------------------------------------------------------------------
// ptw_obuf
// Two-entry result buffer: a two-slot FIFO with read and write pointers.
// ----------------------------------------------------------------------------
`default_nettype none

module ptw_obuf
    import ptw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  ptw_result_t push_data,
    input  logic        pop,
    output logic        full,
    output logic        valid,
    output ptw_result_t head
);

    ptw_result_t mem_reg [2];
    logic        wr_ptr_reg;
    logic        wr_ptr_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign full  = (count_reg == 2'd2);
    assign valid = (count_reg != 2'd0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // hold payload until written over
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/four_level_page_table_walker_core.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core
// Four-level page walker: one walk step per item, entry reads go out as results.
// ----------------------------------------------------------------------------
// Flow: an accepted item waits in the input register; its result (if any) is
//   pushed into the result buffer, whose head drives out_valid and the outputs.
// Throughput: one item per cycle; the input register advances when the
//   two-entry result buffer has room, so a stalled result does not stop intake
//   until both buffer slots are taken.
// Reset: walk state (idle, level 0, saved address and count) and all valid
//   bits clear asynchronously; no walk is pending after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module four_level_page_table_walker_core
    import ptw_pkg::*;
#(
    parameter int PHYS_FRAME_BITS = DEF_PHYS_FRAME_BITS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                action,
    input  logic [VA_W-1:0]     linear_addr,
    input  logic [PA_W-1:0]     table_base,
    input  logic [SIZE_W-1:0]   request_size,
    input  logic [ENTRY_W-1:0]  entry_data,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [1:0]          result_kind,
    output logic [PA_W-1:0]     entry_address,
    output logic [PA_W-1:0]     phys_addr,
    output logic [LEN_W-1:0]    copy_length
);

    // Input register: holds the accepted item until its step is done.
    logic         s1_valid_reg;
    logic         s1_valid_next;
    ptw_item_t    s1_item_reg;

    // Walk state, updated when the item in the input register retires.
    ptw_state_t   walk_reg;
    ptw_state_t   walk_next;

    logic         in_accept;
    logic         s1_adv;
    logic         step_has;
    ptw_result_t  step_result;
    logic         buf_push;
    logic         buf_pop;
    logic         buf_full;
    ptw_result_t  buf_head;

    ptw_step #(
        .PHYS_FRAME_BITS (PHYS_FRAME_BITS)
    ) u_step (
        .item       (s1_item_reg),
        .state      (walk_reg),
        .has_result (step_has),
        .result     (step_result),
        .state_next (walk_next)
    );

    // Retire the held item when it makes no result or the buffer has a slot.
    assign s1_adv    = s1_valid_reg && (!step_has || !buf_full);
    assign in_stall  = s1_valid_reg && !s1_adv;
    assign in_accept = in_valid && !in_stall;
    assign buf_push  = s1_adv && step_has;
    assign buf_pop   = out_valid && !out_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept) begin
            s1_valid_next = 1'b1;
        end else if (s1_adv) begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            walk_reg     <= '{busy: 1'b0, level: 2'd0, linear_address: '0, byte_count: '0};
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (s1_adv) begin
                walk_reg <= walk_next;
            end
        end
    end

    // Capture the item payload on acceptance.
    always_ff @(posedge clk)
    begin
        if (in_accept) begin
            s1_item_reg <= '{action: ptw_action_t'(action),
                             linear_addr: linear_addr,
                             table_base: table_base,
                             request_size: request_size,
                             entry_data: entry_data};
        end
    end

    ptw_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (buf_push),
        .push_data (step_result),
        .pop       (buf_pop),
        .full      (buf_full),
        .valid     (out_valid),
        .head      (buf_head)
    );

    assign result_kind   = buf_head.kind;
    assign entry_address = buf_head.entry_address;
    assign phys_addr     = buf_head.phys_addr;
    assign copy_length   = buf_head.copy_length;

    // The buffer is never written while both slots are taken.
    assert property (@(posedge clk) disable iff (!rst_n) !(buf_push && buf_full))
        else $error("result pushed into full buffer");

    // A start that meets a pending walk gives nothing.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s1_item_reg.action == ACT_START && walk_reg.busy) |-> !step_has)
        else $error("start during walk produced a result");

    // A done or fault ends the walk.
    assert property (@(posedge clk) disable iff (!rst_n)
        (buf_push && step_result.kind != KIND_READ) |=> !walk_reg.busy)
        else $error("walk still busy after final result");

    // A finished translation never copies past the page.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && result_kind == KIND_DONE) |-> (copy_length <= PAGE_BYTES))
        else $error("copy length beyond page size");

endmodule

`default_nettype wire

>>> tb/four_level_page_table_walker_core_tb.sv
// ----------------------------------------------------------------------------
// four_level_page_table_walker_core_tb
// Drives translate requests and returned table entries into the walker core,
// predicts each read request, completion and fault in a scoreboard that keeps
// its own copy of the walk state, and compares every result field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module four_level_page_table_walker_core_tb
    import ptw_pkg::*;
();

    // Scoreboard: tracks the walk exactly as the core should, holds the
    // results still owed by the core, and counts mismatches.
    class walk_scoreboard;
        localparam int FRAME_BITS = DEF_PHYS_FRAME_BITS;

        bit              walk_busy;
        bit [1:0]        walk_level;
        bit [VA_W-1:0]   saved_va;
        bit [LEN_W-1:0]  saved_count;
        ptw_result_t     owed_results[$];
        int              mismatches;

        function new();
            walk_busy   = 1'b0;
            walk_level  = 2'd0;
            saved_va    = '0;
            saved_count = '0;
            mismatches  = 0;
        endfunction

        // Bits lo..FRAME_BITS-1 set.
        function bit [ENTRY_W-1:0] frame_mask(int lo);
            return ((64'd1 << FRAME_BITS) - 64'd1) & ~((64'd1 << lo) - 64'd1);
        endfunction

        function bit [IDX_W-1:0] table_index(bit [1:0] lvl);
            int sh;
            sh = 39 - 9 * int'(lvl);
            return IDX_W'(saved_va >> sh);
        endfunction

        function ptw_result_t fault_result();
            ptw_result_t r;
            walk_busy          = 1'b0;
            r.kind             = KIND_FAULT;
            r.entry_address    = '0;
            r.phys_addr        = '0;
            r.copy_length      = '0;
            return r;
        endfunction

        function ptw_result_t read_or_fault(bit [PA_W-1:0] addr);
            ptw_result_t r;
            if (addr == '0)
                return fault_result();
            r.kind             = KIND_READ;
            r.entry_address    = addr;
            r.phys_addr        = '0;
            r.copy_length      = '0;
            return r;
        endfunction

        function ptw_result_t finish_walk(bit [PA_W-1:0] pa);
            ptw_result_t      r;
            bit [LEN_W-1:0]   left;
            left               = PAGE_BYTES - {1'b0, pa[PAGE_SHIFT-1:0]};
            walk_busy          = 1'b0;
            r.kind             = KIND_DONE;
            r.entry_address    = '0;
            r.phys_addr        = pa;
            r.copy_length      = (saved_count < left) ? saved_count : left;
            return r;
        endfunction

        // Advance the walk by one accepted item; return 1 if it owes a result.
        function bit note_input(ptw_item_t it);
            ptw_result_t      r;
            bit [ENTRY_W-1:0] e;
            bit [PA_W-1:0]    next_addr;
            if (it.action == ACT_START) begin
                if (walk_busy)
                    return 1'b0;
                saved_va    = it.linear_addr;
                saved_count = (it.request_size < 32'd4096) ? LEN_W'(it.request_size)
                                                           : PAGE_BYTES;
                walk_level  = 2'd0;
                if (it.table_base == '0) begin
                    r = fault_result();
                end
                else begin
                    walk_busy = 1'b1;
                    next_addr = {it.table_base[PA_W-1:4], 4'h0}
                              + {40'd0, table_index(2'd0), 3'b000};
                    r = read_or_fault(next_addr);
                end
            end
            else begin
                if (!walk_busy)
                    return 1'b0;
                e = it.entry_data;
                if (walk_level != 2'd3 && !e[PRESENT_BIT])
                    r = fault_result();
                else if (walk_level == 2'd1 && e[LARGE_BIT])
                    r = finish_walk(PA_W'(e & frame_mask(30)) + {22'd0, saved_va[29:0]});
                else if (walk_level == 2'd2 && e[LARGE_BIT])
                    r = finish_walk(PA_W'(e & frame_mask(21)) + {31'd0, saved_va[20:0]});
                else if (walk_level == 2'd3) begin
                    if ((e & frame_mask(PAGE_SHIFT)) == '0)
                        r = fault_result();
                    else
                        r = finish_walk(PA_W'(e & frame_mask(PAGE_SHIFT))
                                        + {40'd0, saved_va[11:0]});
                end
                else begin
                    walk_level = walk_level + 2'd1;
                    next_addr  = PA_W'(e & frame_mask(PAGE_SHIFT))
                               + {40'd0, table_index(walk_level), 3'b000};
                    r = read_or_fault(next_addr);
                end
            end
            owed_results.push_back(r);
            return 1'b1;
        endfunction

        function int pending();
            return owed_results.size();
        endfunction

        task report(string msg);
            if (mismatches < 40)
                $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(ptw_result_t got);
            ptw_result_t want;
            if (owed_results.size() == 0) begin
                report($sformatf("result kind %0d with none owed", got.kind));
                return;
            end
            want = owed_results.pop_front();
            if (got.kind != want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.entry_address != want.entry_address)
                report($sformatf("entry_address %h, want %h",
                                 got.entry_address, want.entry_address));
            if (got.phys_addr != want.phys_addr)
                report($sformatf("phys_addr %h, want %h",
                                 got.phys_addr, want.phys_addr));
            if (got.copy_length != want.copy_length)
                report($sformatf("copy_length %0d, want %0d",
                                 got.copy_length, want.copy_length));
        endtask
    endclass

    localparam int LONG_HOLD = 150;

    logic                clk;
    logic                rst_n            = 1'b0;
    logic                in_valid         = 1'b0;
    logic                in_stall;
    logic                action           = 1'b0;
    logic [VA_W-1:0]     linear_addr      = '0;
    logic [PA_W-1:0]     table_base       = '0;
    logic [SIZE_W-1:0]   request_size     = '0;
    logic [ENTRY_W-1:0]  entry_data       = '0;
    logic                out_valid;
    logic                out_stall        = 1'b0;
    logic [1:0]          result_kind;
    logic [PA_W-1:0]     entry_address;
    logic [PA_W-1:0]     phys_addr;
    logic [LEN_W-1:0]    copy_length;

    walk_scoreboard      walks;
    bit                  sender_quiet = 1'b0;   // no gaps between items
    bit                  long_hold    = 1'b0;   // ask the sink for a long stall

    four_level_page_table_walker_core DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_stall         (in_stall),
        .action           (action),
        .linear_addr      (linear_addr),
        .table_base       (table_base),
        .request_size     (request_size),
        .entry_data       (entry_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .result_kind      (result_kind),
        .entry_address    (entry_address),
        .phys_addr        (phys_addr),
        .copy_length      (copy_length)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Build a translate request; the entry field carries noise the core ignores.
    function automatic ptw_item_t start_req(bit [VA_W-1:0] va, bit [PA_W-1:0] base,
                                            bit [SIZE_W-1:0] size);
        ptw_item_t it;
        it.action          = ACT_START;
        it.linear_addr     = va;
        it.table_base      = base;
        it.request_size    = size;
        it.entry_data      = {$urandom, $urandom};
        return it;
    endfunction

    // Build a returned table entry; the request fields carry noise.
    function automatic ptw_item_t table_entry(bit [ENTRY_W-1:0] e);
        ptw_item_t it;
        it.action          = ACT_ENTRY;
        it.linear_addr     = VA_W'({$urandom, $urandom});
        it.table_base      = PA_W'({$urandom, $urandom});
        it.request_size    = $urandom;
        it.entry_data      = e;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until accepted, then
    // let the scoreboard advance its walk.
    task automatic send_item(input ptw_item_t it, output bit produced);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid        <= 1'b1;
        action          <= it.action;
        linear_addr     <= it.linear_addr;
        table_base      <= it.table_base;
        request_size    <= it.request_size;
        entry_data      <= it.entry_data;
        do @(posedge clk); while (in_stall);
        produced = walks.note_input(it);
    endtask

    // Result sink: stalls at random before each item, with stall-free stretches and
    // a long hold on request so the core backs up into its input.
    initial
    begin : result_sink
        int          n;
        int          taken;
        ptw_result_t got;
        taken = 0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            n = ((taken / 64) % 4 == 2) ? 0 : $urandom_range(0, 3);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
            got.kind             = ptw_kind_t'(result_kind);
            got.entry_address    = entry_address;
            got.phys_addr        = phys_addr;
            got.copy_length      = copy_length;
            walks.check_result(got);
            taken++;
        end
    end

    initial
    begin : stimulus
        bit               produced;
        int               n;
        int               counted;
        int               lvl;
        bit [VA_W-1:0]    va;
        bit [PA_W-1:0]    base;
        bit [SIZE_W-1:0]  size;
        bit [ENTRY_W-1:0] e;

        walks = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Zero base faults at once.
        send_item(start_req('1, '0, '1), produced);
        // Base with only ignored low bits and a zero top index: zero entry address.
        send_item(start_req('0, 52'h5, 32'd100), produced);
        // Entry with no walk pending: dropped.
        send_item(table_entry('1), produced);

        // All-ones address and a base that wraps the top entry address; large
        // bit set at the top and last levels where it must be ignored; a start
        // arrives mid-walk and must be dropped.
        send_item(start_req('1, 52'hF_FFFF_FFFF_FFF0, '1), produced);
        send_item(table_entry(64'hFFFF_FFFF_FFFF_FFFF), produced);
        send_item(start_req(48'h1, 52'h1000, 32'd8), produced);
        send_item(table_entry(64'hFFFF_FFFF_FFFF_FF7F), produced);
        send_item(table_entry(64'hFFFF_FFFF_FFFF_FF7F), produced);
        send_item(table_entry(64'hFFFF_FFFF_FFFF_FFFF), produced);

        // 1 GiB page with a zero byte count.
        send_item(start_req(48'h1234_5678_9ABC, 52'h8_0000_0012_3000, 32'd0), produced);
        send_item(table_entry(64'h0000_0000_0010_0003), produced);
        send_item(table_entry(64'h8000_0004_C000_0081), produced);

        // 2 MiB page with a byte count of exactly one page.
        send_item(start_req(48'hFEDC_BA98_7654, 52'hA_BCDE_F012_3450, 32'd4096), produced);
        send_item(table_entry(64'h0000_0000_0010_0001), produced);
        send_item(table_entry(64'h0000_0000_0020_0001), produced);
        send_item(table_entry(64'h0000_0009_FFE0_0083), produced);

        // Absent top-level entry.
        send_item(start_req(48'h0000_4000_0000, 52'h2_0000_0000_0000, 32'd64), produced);
        send_item(table_entry(64'hFFFF_FFFF_FFFF_FFFE), produced);

        // Second-level entry address comes out zero.
        send_item(start_req(48'h8000_0000_0000, 52'h3_0000_0000_0000, 32'd64), produced);
        send_item(table_entry(64'h0000_0000_0000_0001), produced);

        // Last-level entry with no frame bits: fault.
        send_item(start_req(48'h7FFF_FFFF_F123, 52'h4_0000_0001_0000, 32'd5000), produced);
        send_item(table_entry(64'h0000_0001_2345_6001), produced);
        send_item(table_entry(64'h0000_0001_2345_6001), produced);
        send_item(table_entry(64'h0000_0001_2345_6001), produced);
        send_item(table_entry(64'hFFFF_FFF0_0000_0FFF), produced);

        // Random walks: mostly well-formed, with some noise and broken steps.
        n       = 0;
        counted = 0;
        while (counted < 1000)
        begin
            sender_quiet = ((n / 80) % 4 == 3);
            if (n == 300 || n == 800)
                long_hold = 1'b1;
            if (n == 600)
            begin
                // Drop valid and wait until every owed result is out.
                in_valid <= 1'b0;
                do @(posedge clk); while (walks.pending() != 0);
            end

            if (!walks.walk_busy)
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    send_item(table_entry({$urandom, $urandom}), produced);
                end
                else
                begin
                    va = VA_W'({$urandom, $urandom});
                    if ($urandom_range(0, 99) < 5)
                        va[VA_W-1:PAGE_SHIFT] = '0;
                    base = PA_W'({$urandom, $urandom});
                    case ($urandom_range(0, 19))
                        0:       base = '0;
                        1:       base = PA_W'($urandom_range(1, 15));
                        default: ;
                    endcase
                    case ($urandom_range(0, 3))
                        0:       size = $urandom;
                        1:       size = $urandom_range(0, 4200);
                        2:       size = $urandom_range(0, 64);
                        default: size = $urandom_range(4090, 4100);
                    endcase
                    send_item(start_req(va, base, size), produced);
                end
            end
            else
            begin
                if ($urandom_range(0, 99) < 4)
                begin
                    send_item(start_req(VA_W'({$urandom, $urandom}),
                                        PA_W'({$urandom, $urandom}), $urandom), produced);
                end
                else
                begin
                    e   = {$urandom, $urandom};
                    lvl = walks.walk_level;
                    if (lvl != 3)
                        e[PRESENT_BIT] = ($urandom_range(0, 99) >= 6);
                    if (lvl == 1)
                        e[LARGE_BIT] = ($urandom_range(0, 99) < 20);
                    else if (lvl == 2)
                        e[LARGE_BIT] = ($urandom_range(0, 99) < 30);
                    if ($urandom_range(0, 99) < 3)
                        e[35:12] = '0;
                    send_item(table_entry(e), produced);
                end
            end
            if (produced)
                counted++;
            n++;
        end

        // Drain: wait for every owed result, then wait on for strays.
        in_valid <= 1'b0;
        while (walks.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (walks.mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> four_level_page_table_walker_core.f
rtl/core/ptw_pkg.sv
rtl/core/ptw_step.sv
rtl/core/ptw_obuf.sv
rtl/core/four_level_page_table_walker_core.sv
tb/four_level_page_table_walker_core_tb.sv
